// ===== design/sri_pkg.sv =====
// shared types and constants for the segment / rectangle intersection block
// no dependencies; imported by segment_rect_intersect_top

package sri_pkg;

    // rectangle corners, in the order the edges walk them
    typedef enum logic [1:0] {
        CORNER_LL = 2'd0,
        CORNER_LH = 2'd1,
        CORNER_HH = 2'd2,
        CORNER_HL = 2'd3
    } corner_t;

    localparam int NUM_CORNERS = 4;
    localparam int NUM_EDGES   = 4;

    // edge indexes: left, top, right, bottom
    localparam int EDGE_LEFT   = 0;
    localparam int EDGE_TOP    = 1;
    localparam int EDGE_RIGHT  = 2;
    localparam int EDGE_BOTTOM = 3;

    // sign of one cross product, zero when neither flag is set
    typedef struct packed {
        logic pos;
        logic neg;
    } sign_t;

    // true when two signs do not lie strictly on the same side
    function automatic logic straddles(input sign_t a, input sign_t b);
        straddles = !((a.pos && b.pos) || (a.neg && b.neg));
    endfunction

    localparam int OUT_BYTE_BITS = 8;

endpackage

// ===== design/segment_rect_intersect_top.sv =====
// segment versus axis-aligned rectangle hit test, four-stage pipeline
// depends on sri_pkg (corner codes, sign type, straddle helper)

// usage
//   input stream s_*: one request per item, s_tdata holds eight coordinates of
//   COORD_BITS each, two's complement: seg start x/y, seg end x/y, rect low x/y,
//   rect high x/y (lowest bits first). output stream m_*: one result per request,
//   m_tdata[0] is the touches flag, upper bits zero.
//   a hit is an end point inside the rectangle (bounds included) or a touch or
//   crossing of any of the four rectangle edges; collinear overlap counts.
// pipeline
//   stage 1: coordinate differences, all magnitude compares (inside, bounding box)
//   stage 2: four signed 2*(COORD_BITS+1)-bit products, shared by the four corners
//   stage 3: one wide subtract per corner, reduced to a sign
//   stage 4: per-edge combine into the output register
//   stage 1 loads on accept, then stages 2, 3 and 4 in order; m_tvalid is the
//   stage 4 valid bit. one request per cycle sustained while m_tready stays high;
//   every stage then takes a new request each cycle
// reset and stall
//   rst_n clears all stage valid bits; no results are pending after reset.
//   when m_tready is low the pipeline compacts into empty stages and then holds;
//   s_tready drops only when every stage holds a request, nothing is lost
module segment_rect_intersect_top #(
    parameter int COORD_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // seg_start_x, seg_start_y, seg_end_x, seg_end_y,
    // rect_low_x, rect_low_y, rect_high_x, rect_high_y (lowest first)
    input  logic [8*COORD_BITS-1:0]             s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // touches, then seven zero bits
    output logic [sri_pkg::OUT_BYTE_BITS-1:0]   m_tdata
);
    import sri_pkg::*;

    localparam int N = COORD_BITS;
    localparam int D = N + 1;      // coordinate difference
    localparam int P = 2 * D;      // product of two differences
    localparam int W = P + 1;      // difference of two products

    // stage valid bits and enables
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic en1, en2, en3, en4;

    assign en4      = !v4_reg || m_tready;
    assign en3      = !v3_reg || en4;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign s_tready = en1;

    // unpack the request
    logic signed [N-1:0] ax, ay, bx, by, lx, ly, hx, hy;
    assign ax = s_tdata[0*N +: N];
    assign ay = s_tdata[1*N +: N];
    assign bx = s_tdata[2*N +: N];
    assign by = s_tdata[3*N +: N];
    assign lx = s_tdata[4*N +: N];
    assign ly = s_tdata[5*N +: N];
    assign hx = s_tdata[6*N +: N];
    assign hy = s_tdata[7*N +: N];

    // ---------------- stage 1 ----------------
    // segment direction and corner offsets from the start point
    logic signed [D-1:0] ex_next, ey_next, dlx_next, dhx_next, dly_next, dhy_next;
    logic signed [D-1:0] ex_reg, ey_reg, dlx_reg, dhx_reg, dly_reg, dhy_reg;
    logic                inside_next, inside1_reg;
    logic [NUM_EDGES-1:0] box_next, box1_reg;

    // segment entirely below / above a given value on one axis
    logic xlt_l, xgt_l, xlt_h, xgt_h, ylt_l, ygt_l, ylt_h, ygt_h;
    logic in_a, in_b;

    always_comb
    begin
        ex_next  = D'(bx) - D'(ax);
        ey_next  = D'(by) - D'(ay);
        dlx_next = D'(lx) - D'(ax);
        dhx_next = D'(hx) - D'(ax);
        dly_next = D'(ly) - D'(ay);
        dhy_next = D'(hy) - D'(ay);

        in_a = (ax >= lx) && (ax <= hx) && (ay >= ly) && (ay <= hy);
        in_b = (bx >= lx) && (bx <= hx) && (by >= ly) && (by <= hy);
        inside_next = in_a || in_b;

        xlt_l = (ax < lx) && (bx < lx);
        xgt_l = (ax > lx) && (bx > lx);
        xlt_h = (ax < hx) && (bx < hx);
        xgt_h = (ax > hx) && (bx > hx);
        ylt_l = (ay < ly) && (by < ly);
        ygt_l = (ay > ly) && (by > ly);
        ylt_h = (ay < hy) && (by < hy);
        ygt_h = (ay > hy) && (by > hy);

        // bounding-box overlap per edge; an edge spans min..max of its corners.
        // for axis-aligned edges the edge-side straddle of the segment end points
        // reduces to this same overlap, so it needs no separate term
        box_next[EDGE_LEFT]   = !(xlt_l || xgt_l || (ylt_l && ylt_h) || (ygt_l && ygt_h));
        box_next[EDGE_RIGHT]  = !(xlt_h || xgt_h || (ylt_l && ylt_h) || (ygt_l && ygt_h));
        box_next[EDGE_TOP]    = !(ylt_h || ygt_h || (xlt_l && xlt_h) || (xgt_l && xgt_h));
        box_next[EDGE_BOTTOM] = !(ylt_l || ygt_l || (xlt_l && xlt_h) || (xgt_l && xgt_h));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (en1)
        begin
            v1_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1 && s_tvalid)
        begin
            ex_reg      <= ex_next;
            ey_reg      <= ey_next;
            dlx_reg     <= dlx_next;
            dhx_reg     <= dhx_next;
            dly_reg     <= dly_next;
            dhy_reg     <= dhy_next;
            inside1_reg <= inside_next;
            box1_reg    <= box_next;
        end
    end

    // ---------------- stage 2 ----------------
    // cross with corner c: ex*(cy-ay) - ey*(cx-ax); four products cover all corners
    logic signed [P-1:0] pl_next, ph_next, ql_next, qh_next;
    logic signed [P-1:0] pl_reg, ph_reg, ql_reg, qh_reg;
    logic                inside2_reg;
    logic [NUM_EDGES-1:0] box2_reg;

    assign pl_next = P'(ex_reg) * P'(dly_reg);
    assign ph_next = P'(ex_reg) * P'(dhy_reg);
    assign ql_next = P'(ey_reg) * P'(dlx_reg);
    assign qh_next = P'(ey_reg) * P'(dhx_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (en2)
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en2 && v1_reg)
        begin
            pl_reg      <= pl_next;
            ph_reg      <= ph_next;
            ql_reg      <= ql_next;
            qh_reg      <= qh_next;
            inside2_reg <= inside1_reg;
            box2_reg    <= box1_reg;
        end
    end

    // ---------------- stage 3 ----------------
    logic signed [W-1:0] cross_val [NUM_CORNERS];
    sign_t               sign_next [NUM_CORNERS];
    sign_t               sign_reg  [NUM_CORNERS];
    logic                inside3_reg;
    logic [NUM_EDGES-1:0] box3_reg;

    always_comb
    begin
        cross_val[CORNER_LL] = W'(pl_reg) - W'(ql_reg);
        cross_val[CORNER_LH] = W'(ph_reg) - W'(ql_reg);
        cross_val[CORNER_HH] = W'(ph_reg) - W'(qh_reg);
        cross_val[CORNER_HL] = W'(pl_reg) - W'(qh_reg);
        for (int i = 0; i < NUM_CORNERS; i++)
        begin
            sign_next[i].neg = cross_val[i][W-1];
            sign_next[i].pos = !cross_val[i][W-1] && (|cross_val[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else if (en3)
        begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en3 && v2_reg)
        begin
            sign_reg    <= sign_next;
            inside3_reg <= inside2_reg;
            box3_reg    <= box2_reg;
        end
    end

    // ---------------- stage 4 ----------------
    logic [NUM_EDGES-1:0] edge_hit;
    logic                 touches_next, touches_reg;

    always_comb
    begin
        edge_hit[EDGE_LEFT]   = box3_reg[EDGE_LEFT] &&
                                straddles(sign_reg[CORNER_LL], sign_reg[CORNER_LH]);
        edge_hit[EDGE_TOP]    = box3_reg[EDGE_TOP] &&
                                straddles(sign_reg[CORNER_LH], sign_reg[CORNER_HH]);
        edge_hit[EDGE_RIGHT]  = box3_reg[EDGE_RIGHT] &&
                                straddles(sign_reg[CORNER_HH], sign_reg[CORNER_HL]);
        edge_hit[EDGE_BOTTOM] = box3_reg[EDGE_BOTTOM] &&
                                straddles(sign_reg[CORNER_HL], sign_reg[CORNER_LL]);
        touches_next = inside3_reg || (|edge_hit);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
        end
        else if (en4)
        begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en4 && v3_reg)
        begin
            touches_reg <= touches_next;
        end
    end

    assign m_tvalid = v4_reg;
    assign m_tdata  = {{(OUT_BYTE_BITS-1){1'b0}}, touches_reg};

endmodule

// ===== test/segment_rect_intersect_checker.sv =====
`timescale 1ns / 1ps
// result checker for segment_rect_intersect_top: watches both streams, predicts
// the touches flag of each accepted request and compares it with the results
// depends on sri_pkg for the output byte width

module segment_rect_intersect_checker #(
    parameter int COORD_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    input  logic                                s_tready,
    input  logic [8*COORD_BITS-1:0]             s_tdata,
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic [sri_pkg::OUT_BYTE_BITS-1:0]   m_tdata,
    output int                                  failures,
    output int                                  outstanding
);

    // field slots inside s_tdata
    localparam int SX  = 0;
    localparam int SY  = 1;
    localparam int EX  = 2;
    localparam int EY  = 3;
    localparam int RLX = 4;
    localparam int RLY = 5;
    localparam int RHX = 6;
    localparam int RHY = 7;

    bit touches_due [$];
    bit touches_want;
    int fail_count = 0;

    function automatic longint larger(longint a, longint b);
        return (a > b) ? a : b;
    endfunction

    function automatic longint smaller(longint a, longint b);
        return (a < b) ? a : b;
    endfunction

    // sign of (b - a) x (c - a); products taken at 128 bits, exact for coordinates up to 63 bits
    function automatic int turn_sign(longint ax, longint ay, longint bx, longint by,
                                     longint cx, longint cy);
        logic signed [127:0] d;
        d = 128'(bx - ax) * 128'(cy - ay) - 128'(cx - ax) * 128'(by - ay);
        if (d > 0)
            return 1;
        else if (d < 0)
            return -1;
        return 0;
    endfunction

    function automatic bit edge_crossed(longint ax, longint ay, longint bx, longint by,
                                        longint cx, longint cy, longint dx, longint dy);
        int s1, s2, s3, s4;
        if (larger(ax, bx) < smaller(cx, dx) || larger(cx, dx) < smaller(ax, bx) ||
            larger(ay, by) < smaller(cy, dy) || larger(cy, dy) < smaller(ay, by))
            return 1'b0;
        s1 = turn_sign(ax, ay, bx, by, cx, cy);
        s2 = turn_sign(ax, ay, bx, by, dx, dy);
        s3 = turn_sign(cx, cy, dx, dy, ax, ay);
        s4 = turn_sign(cx, cy, dx, dy, bx, by);
        return (s1 * s2 <= 0) && (s3 * s4 <= 0);
    endfunction

    function automatic bit point_in_box(longint px, longint py, longint lx, longint ly,
                                        longint hx, longint hy);
        return px >= lx && px <= hx && py >= ly && py <= hy;
    endfunction

    // end point inside, or any edge touched: left, top, right, bottom
    function automatic bit segment_touches_rect(logic [8*COORD_BITS-1:0] payload);
        longint c [8];
        logic signed [COORD_BITS-1:0] f;
        for (int i = 0; i < 8; i++)
        begin
            f = payload[i*COORD_BITS +: COORD_BITS];
            c[i] = f;
        end
        return point_in_box(c[SX], c[SY], c[RLX], c[RLY], c[RHX], c[RHY]) ||
               point_in_box(c[EX], c[EY], c[RLX], c[RLY], c[RHX], c[RHY]) ||
               edge_crossed(c[SX], c[SY], c[EX], c[EY], c[RLX], c[RLY], c[RLX], c[RHY]) ||
               edge_crossed(c[SX], c[SY], c[EX], c[EY], c[RLX], c[RHY], c[RHX], c[RHY]) ||
               edge_crossed(c[SX], c[SY], c[EX], c[EY], c[RHX], c[RHY], c[RHX], c[RLY]) ||
               edge_crossed(c[SX], c[SY], c[EX], c[EY], c[RHX], c[RLY], c[RLX], c[RLY]);
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                touches_due = {touches_due, segment_touches_rect(s_tdata)};
            if (m_tvalid && m_tready)
            begin
                if (touches_due.size() == 0)
                begin
                    $error("touches: expected none, got result m_tdata %h", m_tdata);
                    fail_count++;
                end
                else
                begin
                    touches_want = touches_due.pop_front();
                    if (m_tdata[0] !== touches_want)
                    begin
                        $error("touches: expected %0d, got %0d", touches_want, m_tdata[0]);
                        fail_count++;
                    end
                    if (m_tdata[sri_pkg::OUT_BYTE_BITS-1:1] !== '0)
                    begin
                        $error("m_tdata padding: expected 0, got %h",
                               m_tdata[sri_pkg::OUT_BYTE_BITS-1:1]);
                        fail_count++;
                    end
                end
            end
        end
        // registered so the stimulus side reads settled values at the edge
        failures    <= fail_count;
        outstanding <= touches_due.size();
    end

endmodule

// ===== test/segment_rect_intersect_top_tb.sv =====
`timescale 1ns / 1ps
// testbench top for segment_rect_intersect_top: directed and random requests,
// idle and stall patterns, verdict; depends on segment_rect_intersect_checker

module segment_rect_intersect_top_tb;

    localparam int COORD_BITS = 16;
    localparam int PIPE_DEPTH = 4;       // register stages between the two streams
    localparam int ITEMS_PER_PHASE = 550;
    localparam int MAXC = 32767;
    localparam int MINC = -32768;

    // field slots inside s_tdata, lowest first
    localparam int SX  = 0;
    localparam int SY  = 1;
    localparam int EX  = 2;
    localparam int EY  = 3;
    localparam int RLX = 4;
    localparam int RLY = 5;
    localparam int RHX = 6;
    localparam int RHY = 7;

    logic                               clk;
    logic                               rst_n;
    logic                               s_tvalid;
    logic                               s_tready;
    // seg_start_x, seg_start_y, seg_end_x, seg_end_y,
    // rect_low_x, rect_low_y, rect_high_x, rect_high_y (lowest first)
    logic [8*COORD_BITS-1:0]            s_tdata;
    logic                               m_tvalid;
    logic                               m_tready;
    // touches, then seven zero bits
    logic [sri_pkg::OUT_BYTE_BITS-1:0]  m_tdata;

    int check_failures;
    int results_pending;

    // idle rates in percent, changed per phase
    int send_idle_pct = 15;
    int recv_idle_pct = 52;

    segment_rect_intersect_top #(
        .COORD_BITS (COORD_BITS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    segment_rect_intersect_checker #(
        .COORD_BITS (COORD_BITS)
    ) touch_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .failures    (check_failures),
        .outstanding (results_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // hard stop well beyond the slowest legal run
    initial
    begin
        #2_000_000;
        $display("segment_rect_intersect_top verification failed");
        $finish;
    end

    // receiver: ready held for short random stretches at the current stall rate
    initial
    begin
        int hold;
        m_tready = 1'b0;
        forever
        begin
            hold = $urandom_range(1, 3);
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
            repeat (hold) @(posedge clk);
        end
    end

    // random coordinate at most span-1 above base, wrapping at the field width
    function automatic logic [COORD_BITS-1:0] near(logic [COORD_BITS-1:0] base,
                                                   int unsigned span);
        return base + COORD_BITS'($urandom_range(span - 1));
    endfunction

    function automatic logic [COORD_BITS-1:0] pick_extreme();
        case ($urandom_range(5))
            0:       return {1'b1, {(COORD_BITS-1){1'b0}}};
            1:       return {1'b0, {(COORD_BITS-1){1'b1}}};
            2:       return '0;
            3:       return '1;
            4:       return COORD_BITS'(1);
            default: return COORD_BITS'($urandom);
        endcase
    endfunction

    // mostly segments and rectangles close together so edges get touched,
    // plus fully random and extreme fields for bit and inverted-rect coverage
    function automatic logic [8*COORD_BITS-1:0] make_random_request();
        logic [COORD_BITS-1:0] f [8];
        logic [COORD_BITS-1:0] bx, by, t;
        logic [8*COORD_BITS-1:0] payload;
        int unsigned span;
        int kind;
        kind = $urandom_range(9);
        if (kind <= 1)
        begin
            foreach (f[i]) f[i] = COORD_BITS'($urandom);
        end
        else if (kind == 2)
        begin
            foreach (f[i]) f[i] = pick_extreme();
        end
        else
        begin
            case ($urandom_range(3))
                0:       span = 3;
                1:       span = 9;
                2:       span = 64;
                default: span = 2048;
            endcase
            bx = COORD_BITS'($urandom);
            by = COORD_BITS'($urandom);
            f[RLX] = near(bx, span);
            f[RHX] = near(bx, span);
            f[RLY] = near(by, span);
            f[RHY] = near(by, span);
            // most rectangles well ordered, some left inverted
            if ($urandom_range(9) != 0)
            begin
                if ($signed(f[RLX]) > $signed(f[RHX]))
                begin
                    t = f[RLX];
                    f[RLX] = f[RHX];
                    f[RHX] = t;
                end
                if ($signed(f[RLY]) > $signed(f[RHY]))
                begin
                    t = f[RLY];
                    f[RLY] = f[RHY];
                    f[RHY] = t;
                end
            end
            f[SX] = near(bx - COORD_BITS'(span), 3 * span);
            f[SY] = near(by - COORD_BITS'(span), 3 * span);
            f[EX] = near(bx - COORD_BITS'(span), 3 * span);
            f[EY] = near(by - COORD_BITS'(span), 3 * span);
            // snap end points onto edge lines for touching cases
            for (int k = SX; k <= EX; k += 2)
            begin
                if ($urandom_range(2) == 0)
                begin
                    case ($urandom_range(3))
                        0:       f[k]   = f[RLX];
                        1:       f[k]   = f[RHX];
                        2:       f[k+1] = f[RLY];
                        default: f[k+1] = f[RHY];
                    endcase
                end
            end
            // segment running along a vertical edge line
            if (kind == 9)
            begin
                f[SX] = $urandom_range(1) ? f[RLX] : f[RHX];
                f[EX] = f[SX];
            end
            // degenerate segment, a single point
            if ($urandom_range(7) == 0)
            begin
                f[EX] = f[SX];
                f[EY] = f[SY];
            end
        end
        foreach (f[i]) payload[i*COORD_BITS +: COORD_BITS] = f[i];
        return payload;
    endfunction

    // one request: idle cycles at the current rate, then hold valid until accepted
    task automatic offer_request(input logic [8*COORD_BITS-1:0] payload);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= payload;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    task automatic send_coords(input int sx, input int sy, input int ex, input int ey,
                               input int lx, input int ly, input int hx, input int hy);
        logic [8*COORD_BITS-1:0] payload;
        payload[SX*COORD_BITS  +: COORD_BITS] = sx[COORD_BITS-1:0];
        payload[SY*COORD_BITS  +: COORD_BITS] = sy[COORD_BITS-1:0];
        payload[EX*COORD_BITS  +: COORD_BITS] = ex[COORD_BITS-1:0];
        payload[EY*COORD_BITS  +: COORD_BITS] = ey[COORD_BITS-1:0];
        payload[RLX*COORD_BITS +: COORD_BITS] = lx[COORD_BITS-1:0];
        payload[RLY*COORD_BITS +: COORD_BITS] = ly[COORD_BITS-1:0];
        payload[RHX*COORD_BITS +: COORD_BITS] = hx[COORD_BITS-1:0];
        payload[RHY*COORD_BITS +: COORD_BITS] = hy[COORD_BITS-1:0];
        offer_request(payload);
    endtask

    // stop sending and let every outstanding result come back
    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (results_pending != 0) @(posedge clk);
    endtask

    initial
    begin
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: sx, sy, ex, ey, low x, low y, high x, high y
        send_coords(0, 0, 0, 0, -1, -1, 1, 1);                 // point inside
        send_coords(-10, 0, 10, 0, -1, -1, 1, 1);              // passes straight through
        send_coords(-10, 5, 10, 5, -1, -1, 1, 1);              // clear miss above
        send_coords(-2, 0, 0, 2, -1, -1, 1, 1);                // grazes a corner
        send_coords(-5, 1, 5, 1, -1, -1, 1, 1);                // collinear over top edge
        send_coords(3, 1, 5, 1, -1, -1, 1, 1);                 // collinear but disjoint
        send_coords(-2, -1, 2, -1, -1, -1, 1, 1);              // along bottom edge
        send_coords(5, -5, -5, 5, -1, -1, 1, 1);               // diagonal through
        send_coords(2, 0, 2, 0, -1, -1, 1, 1);                 // point outside
        send_coords(1, 0, 1, 0, -1, -1, 1, 1);                 // point on an edge
        send_coords(0, 0, 0, 0, 1, 1, -1, -1);                 // inverted rect, point at center
        send_coords(-5, 0, 5, 0, 1, 1, -1, -1);                // inverted rect, crossing
        send_coords(-3, 0, 3, 0, 0, -5, 0, 5);                 // zero-width rect
        send_coords(-3, -3, 3, 3, 0, 0, 0, 0);                 // point rect on the line
        send_coords(-3, -2, 3, 4, 0, 0, 0, 0);                 // point rect off the line
        send_coords(MINC, MINC, MAXC, MAXC, MINC, MINC, MAXC, MAXC);
        send_coords(MINC, MAXC, MAXC, MINC, MAXC, MAXC, MAXC, MAXC);
        send_coords(MINC, MINC, MAXC, MAXC - 1, MAXC, MAXC, MAXC, MAXC);
        send_coords(MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MINC, MINC);
        send_coords(MINC, 0, MAXC, 0, MAXC, MINC, MINC, MAXC);
        send_coords(MINC, MINC, MINC, MINC, MINC, MINC, MINC, MINC);
        send_coords(MAXC, MINC, MINC, MAXC, -1, -1, 0, 0);

        // random phases: sender light and receiver heavy, swapped, then none
        for (int phase = 0; phase < 3; phase++)
        begin
            wait_results_drained();
            case (phase)
                0:
                begin
                    send_idle_pct = 15;
                    recv_idle_pct = 52;
                end
                1:
                begin
                    send_idle_pct = 52;
                    recv_idle_pct = 15;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                offer_request(make_random_request());
        end

        wait_results_drained();
        // a few pipeline depths more to catch stray results
        repeat (4 * PIPE_DEPTH) @(posedge clk);
        if (check_failures == 0 && results_pending == 0)
            $display("segment_rect_intersect_top verification clean");
        else
            $display("segment_rect_intersect_top verification failed");
        $finish;
    end

endmodule
